// File: rtl/core/circle_overlap_area_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circle overlap area block
// Clock is i_clk, reset is i_rst_n (active low) in every user of these.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_OVERLAP_AREA_DEFINES_SVH
`define CIRCLE_OVERLAP_AREA_DEFINES_SVH

// same-cycle implication, masked during reset
`define COA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define COA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked during reset too
`define COA_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/coa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coa_pkg
// Shared widths, constants, codes and the queue entry type.
// ----------------------------------------------------------------------------
package coa_pkg;

    localparam int COORD_BITS   = 16;
    localparam int RAD_BITS     = COORD_BITS - 1;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int SUM_BITS     = RAD_BITS + 1;
    localparam int SQ_BITS      = 2 * SUM_BITS;     // d^2 terms, (r1+r2)^2
    localparam int RSQ_BITS     = 2 * RAD_BITS;     // r^2
    localparam int D2_BITS      = SQ_BITS + 1;
    localparam int PROD_BITS    = 2 * SQ_BITS;      // Heron product
    localparam int ROOT_BITS    = PROD_BITS / 2;
    localparam int XC_BITS      = D2_BITS + 2;      // signed CORDIC x input
    localparam int ANG_BITS     = 32;               // Q30 angle, [0, pi]
    localparam int Z_BITS       = ANG_BITS + 2;
    localparam int CW_BITS      = 45;               // CORDIC datapath
    localparam int NORM_EXP     = 40;
    localparam int CORDIC_STEPS = 31;
    localparam int ISQ_STAGES   = PROD_BITS / 2;
    localparam int COR_LAT      = CORDIC_STEPS + 4;
    localparam int AREA_BITS    = 32;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = 2;

    localparam logic [ANG_BITS-1:0]      PI_Q30      = 32'd3373259426;
    localparam logic signed [Z_BITS-1:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam logic [1:0] REL_INSIDE   = 2'd0;
    localparam logic [1:0] REL_DISJOINT = 2'd1;
    localparam logic [1:0] REL_PARTIAL  = 2'd2;

    localparam logic [ANG_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1
    };

    typedef struct packed {
        logic [1:0]          rel;
        logic                bad;
        logic [D2_BITS-1:0]  d2;
        logic [SQ_BITS-1:0]  sd;   // S2 - D2
        logic [SQ_BITS-1:0]  dt;   // D2 - T2
        logic [RSQ_BITS-1:0] q1;   // r1^2
        logic [RSQ_BITS-1:0] q2;   // r2^2
    } t_q_item;

endpackage

// File: rtl/core/coa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coa_queue
// Small FIFO between the classify front and the area back end.
// ----------------------------------------------------------------------------
module coa_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  coa_pkg::t_q_item i_item,
    input  logic             i_pop,
    output coa_pkg::t_q_item o_item,
    output logic             o_empty,
    output logic             o_full
);

    localparam int AW = coa_pkg::Q_AW;

    coa_pkg::t_q_item r_mem [coa_pkg::Q_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(coa_pkg::Q_DEPTH));
    assign o_item  = r_mem[r_rd];

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule

// File: rtl/core/coa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coa_front
// Orders radii, squares distances and classifies each circle pair.
// ----------------------------------------------------------------------------
module coa_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [coa_pkg::RAD_BITS-1:0]        i_radius_a,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_a_x,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_a_y,
    input  logic [coa_pkg::RAD_BITS-1:0]        i_radius_b,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_b_x,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_b_y,
    input  logic                                i_full,
    output logic                                o_push,
    output coa_pkg::t_q_item                    o_item
);

    localparam int RB = coa_pkg::RAD_BITS;
    localparam int DB = coa_pkg::DIFF_BITS;
    localparam int SB = coa_pkg::SQ_BITS;
    localparam int QB = coa_pkg::RSQ_BITS;
    localparam int D2 = coa_pkg::D2_BITS;

    typedef coa_pkg::t_q_item t_q_item_alias;

    logic en;
    logic r_v1, r_v2, r_v3;

    // stage 1
    logic [RB-1:0]        r_r1, r_r2;
    logic signed [DB-1:0] r_dx, r_dy;
    logic                 r_bad1;
    // stage 2
    logic [SB-1:0]        r_dx2, r_dy2, r_s2, r_t2;
    logic [QB-1:0]        r_q1_2, r_q2_2;
    logic                 r_bad2;
    // stage 3
    t_q_item_alias        r_item;

    logic                     a_ge_b;
    logic signed [2*DB-1:0]   dx_sq, dy_sq;
    logic [SB/2-1:0]          rad_sum;
    logic [RB-1:0]            rad_dif;
    logic [D2-1:0]            d2;
    logic [1:0]               rel;

    assign en      = !i_full || !r_v3;
    assign o_ready = en;
    assign o_push  = r_v3 && !i_full;
    assign o_item  = r_item;

    assign a_ge_b  = (i_radius_a >= i_radius_b);
    assign dx_sq   = r_dx * r_dx;
    assign dy_sq   = r_dy * r_dy;
    assign rad_sum = (SB/2)'(r_r1) + (SB/2)'(r_r2);
    assign rad_dif = r_r1 - r_r2;
    assign d2      = D2'(r_dx2) + D2'(r_dy2);

    always_comb begin
        if (D2'(r_t2) >= d2)      rel = coa_pkg::REL_INSIDE;
        else if (d2 >= D2'(r_s2)) rel = coa_pkg::REL_DISJOINT;
        else                      rel = coa_pkg::REL_PARTIAL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r1   <= a_ge_b ? i_radius_a : i_radius_b;
            r_r2   <= a_ge_b ? i_radius_b : i_radius_a;
            r_dx   <= DB'(i_centre_a_x) - DB'(i_centre_b_x);
            r_dy   <= DB'(i_centre_a_y) - DB'(i_centre_b_y);
            r_bad1 <= (i_radius_a == '0) || (i_radius_b == '0);

            r_dx2  <= dx_sq[SB-1:0];
            r_dy2  <= dy_sq[SB-1:0];
            r_s2   <= rad_sum * rad_sum;
            r_t2   <= SB'(rad_dif * rad_dif);
            r_q1_2 <= r_r1 * r_r1;
            r_q2_2 <= r_r2 * r_r2;
            r_bad2 <= r_bad1;

            r_item.rel <= rel;
            r_item.bad <= r_bad2;
            r_item.d2  <= d2;
            r_item.sd  <= r_s2 - d2[SB-1:0];
            r_item.dt  <= d2[SB-1:0] - r_t2;
            r_item.q1  <= r_q1_2;
            r_item.q2  <= r_q2_2;
        end
    end

endmodule

// File: rtl/core/coa_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coa_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module coa_isqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [coa_pkg::PROD_BITS-1:0]   i_rad,
    output logic [coa_pkg::ROOT_BITS-1:0]   o_root
);

    localparam int PW = coa_pkg::PROD_BITS;
    localparam int NS = coa_pkg::ISQ_STAGES;

    logic [PW-1:0] r_rem  [NS-1];
    logic [PW-1:0] r_root [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam logic [PW-1:0] BIT = PW'(1) << (PW - 2 - 2*j);
        logic [PW-1:0] rem_in, root_in, trial;
        logic          take;

        if (j == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        assign trial = root_in + BIT;
        assign take  = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) r_root[j] <= take ? (root_in >> 1) + BIT : (root_in >> 1);
        end

        if (j < NS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) r_rem[j] <= take ? rem_in - trial : rem_in;
            end
        end
    end

    assign o_root = r_root[NS-1][coa_pkg::ROOT_BITS-1:0];

endmodule

// File: rtl/core/coa_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coa_cordic
// Pipelined vectoring CORDIC: angle of (x, k), k >= 0, Q30 radians.
// ----------------------------------------------------------------------------
module coa_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [coa_pkg::XC_BITS-1:0]   i_x,
    input  logic [coa_pkg::ROOT_BITS-1:0]        i_k,
    output logic [coa_pkg::ANG_BITS-1:0]         o_angle
);

    localparam int XW = coa_pkg::XC_BITS;
    localparam int CW = coa_pkg::CW_BITS;
    localparam int ZW = coa_pkg::Z_BITS;
    localparam int AW = coa_pkg::ANG_BITS;
    localparam int NS = coa_pkg::CORDIC_STEPS;
    // start far negative so a zero vector clamps to a zero angle
    localparam logic signed [ZW-1:0] Z_MIN = {1'b1, {(ZW-1){1'b0}}};

    logic          x_neg;
    logic [XW-1:0] px, py, pm;

    // prep stage
    logic [XW-1:0]        r_px, r_py, r_pm;
    logic signed [ZW-1:0] r_pz;
    // normalize stages
    logic [CW-1:0]        r_n1x, r_n1y, r_n1m, r_n2x, r_n2y;
    logic signed [ZW-1:0] r_n1z, r_n2z;
    logic [CW-1:0]        a_x, a_y, a_m, b_x, b_y, b_m;
    // rotation stages
    logic signed [CW-1:0] r_cx [NS-1];
    logic signed [CW-1:0] r_cy [NS-1];
    logic signed [ZW-1:0] r_cz [NS];
    logic [AW-1:0]        r_ang;

    assign x_neg = i_x[XW-1];
    assign px    = x_neg ? XW'(i_k) : i_x;
    assign py    = x_neg ? -i_x : XW'(i_k);
    assign pm    = (px > py) ? px : py;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= px;
            r_py <= py;
            r_pm <= pm;
            if (pm == '0)  r_pz <= Z_MIN;
            else if (x_neg) r_pz <= coa_pkg::HALF_PI_Q30;
            else            r_pz <= '0;
        end
    end

    // shift by 32, 16, 8 then 4, 2, 1 until the larger part reaches 2^40
    always_comb begin
        a_x = CW'(r_px);
        a_y = CW'(r_py);
        a_m = CW'(r_pm);
        for (int s = 5; s >= 3; s--) begin
            if (a_m < (CW'(1) << (coa_pkg::NORM_EXP + 1 - (1 << s)))) begin
                a_x = a_x << (1 << s);
                a_y = a_y << (1 << s);
                a_m = a_m << (1 << s);
            end
        end
    end

    always_comb begin
        b_x = r_n1x;
        b_y = r_n1y;
        b_m = r_n1m;
        for (int s = 2; s >= 0; s--) begin
            if (b_m < (CW'(1) << (coa_pkg::NORM_EXP + 1 - (1 << s)))) begin
                b_x = b_x << (1 << s);
                b_y = b_y << (1 << s);
                b_m = b_m << (1 << s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n1x <= a_x;
            r_n1y <= a_y;
            r_n1m <= a_m;
            r_n1z <= r_pz;
            r_n2x <= b_x;
            r_n2y <= b_y;
            r_n2z <= r_n1z;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        logic signed [CW-1:0] sx, sy;
        logic signed [ZW-1:0] sz, at;

        if (i == 0) begin : g_first
            assign sx = $signed(r_n2x);
            assign sy = $signed(r_n2y);
            assign sz = r_n2z;
        end else begin : g_next
            assign sx = r_cx[i-1];
            assign sy = r_cy[i-1];
            assign sz = r_cz[i-1];
        end

        assign at = $signed(ZW'(coa_pkg::ATAN_TAB[i]));

        always_ff @(posedge i_clk) begin
            if (i_en) r_cz[i] <= sy[CW-1] ? sz - at : sz + at;
        end

        if (i < NS - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!sy[CW-1]) begin
                        r_cx[i] <= sx + (sy >>> i);
                        r_cy[i] <= sy - (sx >>> i);
                    end else begin
                        r_cx[i] <= sx - (sy >>> i);
                        r_cy[i] <= sy + (sx >>> i);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_ang <= r_cz[NS-1][ZW-1] ? '0 : r_cz[NS-1][AW-1:0];
    end

    assign o_angle = r_ang;

endmodule

// File: rtl/core/coa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coa_back
// Area engine: Heron root, two angle CORDICs, segment sum, output register.
// ----------------------------------------------------------------------------
module coa_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    input  coa_pkg::t_q_item                i_item,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [coa_pkg::AREA_BITS-1:0]   o_overlap_area,
    output logic [1:0]                      o_relation,
    output logic                            o_bad_radius
);

    localparam int QB = coa_pkg::RSQ_BITS;
    localparam int XW = coa_pkg::XC_BITS;
    localparam int PW = coa_pkg::PROD_BITS;
    localparam int KW = coa_pkg::ROOT_BITS;
    localparam int AW = coa_pkg::ANG_BITS;
    localparam int NI = coa_pkg::ISQ_STAGES;
    localparam int NC = coa_pkg::COR_LAT;
    localparam int NV = 2 + NI + NC + 2;
    localparam int MW = QB + AW;       // r^2 * angle
    localparam int RW = MW - 28;       // rounded area before saturation

    typedef struct packed {
        logic [QB-1:0] q1;
        logic [QB-1:0] q2;
        logic [1:0]    rel;
        logic          bad;
    } t_side;

    logic en;
    logic [NV-1:0] r_v;
    logic          r_o_valid;

    coa_pkg::t_q_item r_b1;
    logic [PW-1:0]        r_p;
    logic signed [XW-1:0] r_x1, r_x2;
    t_side                r_s2;

    logic signed [XW-1:0] r_ax1  [NI];
    logic signed [XW-1:0] r_ax2  [NI];
    t_side                r_aside [NI];
    logic [KW-1:0]        r_bk    [NC];
    t_side                r_bside [NC];

    logic [KW-1:0] k;
    logic [AW-1:0] alpha, beta;

    logic [MW-1:0] r_pa, r_pb, r_pin;
    logic [KW-1:0] r_mk;
    t_side         r_mside;

    logic [MW:0]   pos, acc;
    logic [MW-2:0] neg;
    logic [RW-1:0] r_part, r_in;
    t_side         r_sside;
    logic [RW-1:0] sel;

    logic [coa_pkg::AREA_BITS-1:0] r_area;
    logic [1:0]                    r_rel;
    logic                          r_bad;

    assign en    = !r_o_valid || i_ready;
    assign o_pop = !i_empty && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_v       <= {r_v[NV-2:0], o_pop};
            r_o_valid <= r_v[NV-1];
        end
    end

    // queue entry, then Heron product and CORDIC x terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1     <= i_item;
            r_p      <= r_b1.sd * r_b1.dt;
            r_x1     <= XW'(r_b1.d2) + XW'(r_b1.q1) - XW'(r_b1.q2);
            r_x2     <= XW'(r_b1.d2) + XW'(r_b1.q2) - XW'(r_b1.q1);
            r_s2.q1  <= r_b1.q1;
            r_s2.q2  <= r_b1.q2;
            r_s2.rel <= r_b1.rel;
            r_s2.bad <= r_b1.bad;
        end
    end

    coa_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_p),
        .o_root (k)
    );

    // side data delayed alongside the root and angle pipelines
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax1[0]   <= r_x1;
            r_ax2[0]   <= r_x2;
            r_aside[0] <= r_s2;
            for (int j = 1; j < NI; j++) begin
                r_ax1[j]   <= r_ax1[j-1];
                r_ax2[j]   <= r_ax2[j-1];
                r_aside[j] <= r_aside[j-1];
            end
            r_bk[0]    <= k;
            r_bside[0] <= r_aside[NI-1];
            for (int j = 1; j < NC; j++) begin
                r_bk[j]    <= r_bk[j-1];
                r_bside[j] <= r_bside[j-1];
            end
        end
    end

    coa_cordic u_cordic_a (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r_ax1[NI-1]),
        .i_k     (k),
        .o_angle (alpha)
    );

    coa_cordic u_cordic_b (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r_ax2[NI-1]),
        .i_k     (k),
        .o_angle (beta)
    );

    // segment products, then sum, triangle term and rounding
    assign pos = (MW+1)'(r_pa) + (MW+1)'(r_pb);
    assign neg = {r_mk, 29'd0};
    assign acc = (pos > (MW+1)'(neg)) ? pos - (MW+1)'(neg) : '0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa    <= r_bside[NC-1].q1 * alpha;
            r_pb    <= r_bside[NC-1].q2 * beta;
            r_pin   <= r_bside[NC-1].q2 * coa_pkg::PI_Q30;
            r_mk    <= r_bk[NC-1];
            r_mside <= r_bside[NC-1];

            r_part  <= RW'((acc + (MW+1)'(32'h2000_0000)) >> 30);
            r_in    <= RW'(((MW+1)'(r_pin) + (MW+1)'(32'h2000_0000)) >> 30);
            r_sside <= r_mside;
        end
    end

    always_comb begin
        case (r_sside.rel)
            coa_pkg::REL_INSIDE:  sel = r_in;
            coa_pkg::REL_PARTIAL: sel = r_part;
            default:              sel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_sside.bad)
                r_area <= '0;
            else if (|sel[RW-1:coa_pkg::AREA_BITS])
                r_area <= '1;
            else
                r_area <= sel[coa_pkg::AREA_BITS-1:0];
            r_rel <= r_sside.rel;
            r_bad <= r_sside.bad;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_overlap_area = r_area;
    assign o_relation     = r_rel;
    assign o_bad_radius   = r_bad;

endmodule

// File: rtl/core/circle_overlap_area.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_overlap_area
// Overlap area of two circles, fully pipelined, one query per unstalled clock.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready carry one query transaction: two radii
// (unsigned, 1/64 units) and two centres (signed, 1/64 units).
// Output channel: o_valid / i_ready carry one result transaction: area in
// 1/4096 square units (rounded, saturated at 2^32-1), the relation code
// (inside, disjoint, partial) and a flag for a zero radius, which forces
// the area to zero.
// Throughput: one transaction per cycle while the receiver does not stall.
// The back end holds the 32-stage square root of the Heron product and
// the 35-stage CORDIC angle pipelines.
// The classify front (3 stages) feeds a 4-entry queue; the back end only
// advances while its output register is free or being taken, so a receiver
// stall freezes the back end, the queue fills, and then o_ready drops.
// Reset (synchronous, active low) empties the queue and all valid bits;
// no result is presented afterwards until a new query arrives.
// ----------------------------------------------------------------------------
module circle_overlap_area (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [coa_pkg::RAD_BITS-1:0]          i_radius_a,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_a_x,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_a_y,
    input  logic [coa_pkg::RAD_BITS-1:0]          i_radius_b,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_b_x,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_b_y,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [coa_pkg::AREA_BITS-1:0]         o_overlap_area,
    output logic [1:0]                            o_relation,
    output logic                                  o_bad_radius
);

    // front to queue
    logic             push;
    coa_pkg::t_q_item push_item;
    logic             q_full;
    // queue to back end
    logic             pop;
    coa_pkg::t_q_item pop_item;
    logic             q_empty;

    coa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_radius_a   (i_radius_a),
        .i_centre_a_x (i_centre_a_x),
        .i_centre_a_y (i_centre_a_y),
        .i_radius_b   (i_radius_b),
        .i_centre_b_x (i_centre_b_x),
        .i_centre_b_y (i_centre_b_y),
        .i_full       (q_full),
        .o_push       (push),
        .o_item       (push_item)
    );

    coa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Heron root, both half angles, segment sum, output register
    coa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_item         (pop_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_overlap_area (o_overlap_area),
        .o_relation     (o_relation),
        .o_bad_radius   (o_bad_radius)
    );

endmodule

// File: rtl/core/coa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coa_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "circle_overlap_area_defines.svh"

module coa_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [coa_pkg::AREA_BITS-1:0]       o_overlap_area,
    input logic [1:0]                          o_relation,
    input logic                                o_bad_radius
);

    `COA_ASSERT_NEXT(a_hold_valid, o_valid && !i_ready, o_valid, "result dropped while stalled")
    `COA_ASSERT_NEXT(a_hold_data, o_valid && !i_ready, $stable(o_overlap_area) && $stable(o_relation) && $stable(o_bad_radius), "result changed while stalled")
    `COA_ASSERT_NOW(a_bad_zero, o_valid && o_bad_radius, o_overlap_area == '0, "zero radius with nonzero area")
    `COA_ASSERT_NOW(a_apart_zero, o_valid && (o_relation == coa_pkg::REL_DISJOINT), o_overlap_area == '0, "disjoint pair with nonzero area")
    `COA_ASSERT_ALWAYS(a_reset_idle, !i_rst_n, !o_valid, "result valid after reset")

endmodule

bind circle_overlap_area coa_checker u_coa_checker (.*);

// File: verif/circle_overlap_area_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_overlap_area_checker
// Watches both channels, predicts each query's overlap area, relation and
// zero-radius flag, and compares results in order. Reports a mismatch count.
// ----------------------------------------------------------------------------
module circle_overlap_area_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic                                  i_in_ready,
    input  logic [coa_pkg::RAD_BITS-1:0]          i_radius_a,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_a_x,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_a_y,
    input  logic [coa_pkg::RAD_BITS-1:0]          i_radius_b,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_b_x,
    input  logic signed [coa_pkg::COORD_BITS-1:0] i_centre_b_y,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic [coa_pkg::AREA_BITS-1:0]         i_overlap_area,
    input  logic [1:0]                            i_relation,
    input  logic                                  i_bad_radius,
    output int                                    o_fail_count,
    output int                                    o_pending
);

    typedef struct {
        logic [coa_pkg::AREA_BITS-1:0] area;
        logic [1:0]                    rel;
        logic                          bad;
    } t_overlap;

    t_overlap expected_overlaps[$];

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // vectoring CORDIC, y >= 0, Q30 result in [0, pi]
    function automatic longint unsigned half_angle(longint x, longint y);
        longint z, t, m;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = coa_pkg::HALF_PI_Q30;
        end
        m = (x > y) ? x : y;
        if (m == 0) return 0;
        while (m < (64'sd1 <<< coa_pkg::NORM_EXP)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < coa_pkg::CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                t = x + shr_floor(y, i);
                y = y - shr_floor(x, i);
                z = z + longint'(coa_pkg::ATAN_TAB[i]);
            end else begin
                t = x - shr_floor(y, i);
                y = y + shr_floor(x, i);
                z = z - longint'(coa_pkg::ATAN_TAB[i]);
            end
            x = t;
        end
        return (z < 0) ? 0 : longint'(z);
    endfunction

    function automatic t_overlap predict_overlap(
        longint unsigned ra, longint ax, longint ay,
        longint unsigned rb, longint bx, longint by);
        t_overlap res;
        longint unsigned r1, r2, d2, s2, t2, area, k, alpha, beta, pos, neg, acc;
        longint dx, dy, q1, q2;
        r1 = (ra >= rb) ? ra : rb;
        r2 = (ra >= rb) ? rb : ra;
        dx = ax - bx;
        dy = ay - by;
        d2 = dx * dx + dy * dy;
        s2 = (r1 + r2) * (r1 + r2);
        t2 = (r1 - r2) * (r1 - r2);
        area = 0;
        res.bad = (ra == 0 || rb == 0);
        if (t2 >= d2) begin
            res.rel = coa_pkg::REL_INSIDE;
            area = (r2 * r2 * longint'(coa_pkg::PI_Q30) + (64'd1 << 29)) >> 30;
        end else if (d2 >= s2) begin
            res.rel = coa_pkg::REL_DISJOINT;
        end else begin
            res.rel = coa_pkg::REL_PARTIAL;
            k = int_sqrt((s2 - d2) * (d2 - t2));
            q1 = r1 * r1;
            q2 = r2 * r2;
            alpha = half_angle(longint'(d2) + q1 - q2, k);
            beta  = half_angle(longint'(d2) + q2 - q1, k);
            pos = q1 * alpha + q2 * beta;
            neg = k << 29;
            acc = (pos > neg) ? pos - neg : 0;
            area = (acc + (64'd1 << 29)) >> 30;
        end
        if (res.bad) area = 0;
        if (area > 64'hFFFF_FFFF) area = 64'hFFFF_FFFF;
        res.area = area[31:0];
        return res;
    endfunction

    assign o_pending = expected_overlaps.size();

    always @(posedge i_clk) begin
        t_overlap exp_r;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && i_in_ready)
                expected_overlaps.push_back(predict_overlap(
                    i_radius_a, i_centre_a_x, i_centre_a_y,
                    i_radius_b, i_centre_b_x, i_centre_b_y));
            if (i_out_valid && i_out_ready) begin
                if (expected_overlaps.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result transaction area=%0d", i_overlap_area);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_overlaps.pop_front();
                    if (exp_r.area !== i_overlap_area || exp_r.rel !== i_relation ||
                        exp_r.bad !== i_bad_radius) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp area=%0d rel=%0d bad=%0d, got %0d %0d %0d",
                                exp_r.area, exp_r.rel, exp_r.bad,
                                i_overlap_area, i_relation, i_bad_radius);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: verif/tb_circle_overlap_area.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_overlap_area
// Drives directed and random circle pairs with bursty input and a stalling
// receiver; the checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_circle_overlap_area;

    localparam int RB = coa_pkg::RAD_BITS;
    localparam int CB = coa_pkg::COORD_BITS;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic [RB-1:0] rad_a = '0, rad_b = '0;
    logic signed [CB-1:0] ax = '0, ay = '0, bx = '0, by = '0;
    logic in_ready, out_valid, bad_radius;
    logic [coa_pkg::AREA_BITS-1:0] overlap_area;
    logic [1:0] relation;
    int fail_count, pending;

    always #6 i_clk = ~i_clk;

    circle_overlap_area dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_radius_a(rad_a), .i_centre_a_x(ax), .i_centre_a_y(ay),
        .i_radius_b(rad_b), .i_centre_b_x(bx), .i_centre_b_y(by),
        .o_valid(out_valid), .i_ready(out_ready), .o_overlap_area(overlap_area),
        .o_relation(relation), .o_bad_radius(bad_radius)
    );

    circle_overlap_area_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .i_in_ready(in_ready),
        .i_radius_a(rad_a), .i_centre_a_x(ax), .i_centre_a_y(ay),
        .i_radius_b(rad_b), .i_centre_b_x(bx), .i_centre_b_y(by),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_overlap_area(overlap_area), .i_relation(relation),
        .i_bad_radius(bad_radius), .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern: long open phases, short and long stalls
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!i_rst_n)          out_ready <= 1'b0;
        else if ($time < 4000) out_ready <= 1'b1;   // early stretch, no stall
        else if (r < 70)       out_ready <= 1'b1;
        else                   out_ready <= 1'b0;
    end

    // present one query transaction and hold it until accepted
    task automatic send_query(input logic [RB-1:0] ra, input logic [15:0] xa,
                              input logic [15:0] ya, input logic [RB-1:0] rb,
                              input logic [15:0] xb, input logic [15:0] yb);
        rad_a <= ra; ax <= xa; ay <= ya;
        rad_b <= rb; bx <= xb; by <= yb;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    // small coordinates keep most pairs partial or nested
    task automatic random_geometry_query();
        int sel;
        logic [RB-1:0] ra, rb;
        logic [15:0] xa, ya, xb, yb;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            ra = RB'($urandom_range(1, 4000));
            rb = RB'($urandom_range(1, 4000));
            xa = 16'(int'($urandom_range(0, 8000)) - 4000);
            ya = 16'(int'($urandom_range(0, 8000)) - 4000);
            xb = 16'(int'(xa) + int'($urandom_range(0, 6000)) - 3000);
            yb = 16'(int'(ya) + int'($urandom_range(0, 6000)) - 3000);
        end else begin
            ra = RB'($urandom);
            rb = (sel == 9) ? '0 : RB'($urandom);
            xa = 16'($urandom); ya = 16'($urandom);
            xb = 16'($urandom); yb = 16'($urandom);
        end
        send_query(ra, xa, ya, rb, xb, yb);
    endtask

    initial begin
        int burst;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, nesting, touching, zero radius, partial
        send_query(15'h7FFF, 16'h8000, 16'h8000, 15'h7FFF, 16'h7FFF, 16'h7FFF);
        send_query(15'h7FFF, 16'h0000, 16'h0000, 15'h7FFF, 16'h0000, 16'h0000);
        send_query(15'h7FFF, 16'h7FFF, 16'h8000, 15'h0001, 16'h7FFF, 16'h8000);
        send_query(15'd0, 16'd0, 16'd0, 15'd100, 16'd0, 16'd0);
        send_query(15'd100, 16'd0, 16'd0, 15'd0, 16'd5000, 16'd0);
        send_query(15'd0, 16'd0, 16'd0, 15'd0, 16'd0, 16'd0);
        send_query(15'd64, 16'd0, 16'd0, 15'd64, 16'd128, 16'd0);   // touching
        send_query(15'd128, 16'd0, 16'd0, 15'd64, 16'd64, 16'd0);   // internal tangent
        send_query(15'd64, 16'd0, 16'd0, 15'd64, 16'd64, 16'd0);    // partial
        send_query(15'd1000, 16'd0, 16'd0, 15'd300, 16'd900, 16'd0); // chord past centre
        send_query(15'd1000, 16'd0, 16'd0, 15'd300, 16'd1200, 16'd0);
        send_query(15'd300, 16'hFF00, 16'hFF00, 15'd1000, 16'd500, 16'd500);
        send_query(15'd1, 16'd0, 16'd0, 15'd1, 16'd1, 16'd0);
        send_query(15'h7FFF, 16'h8000, 16'd0, 15'h7FFF, 16'h7FFF, 16'd0);
        send_query(15'h5555, 16'h5555, 16'hAAAA, 15'h2AAA, 16'hAAAA, 16'h5555);
        drop_valid();

        // everything settles before the random part
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < 1500; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < 1500; b++, n++) random_geometry_query();
            drop_valid();
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/coa_pkg.sv
rtl/core/coa_queue.sv
rtl/core/coa_front.sv
rtl/core/coa_isqrt.sv
rtl/core/coa_cordic.sv
rtl/core/coa_back.sv
rtl/core/circle_overlap_area.sv
rtl/core/coa_checker.sv
verif/circle_overlap_area_checker.sv
verif/tb_circle_overlap_area.sv
